>>> hw/rtl/bmpd_pkg.sv
// bmpd_pkg: types, codes and constants shared by the 24-bit BMP deframer.
// No dependencies; imported by bmpd_hdr, bmp24_pixel_deframer and bmpd_checker.
package bmpd_pkg;

	// Largest accepted image width or height
	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int COORD_W = $clog2(MAX_DIM);

	// File layout
	localparam logic [31:0] HDR_LAST_POS = 32'd53;
	localparam logic [31:0] HDR_BYTES    = 32'd54;
	localparam logic [15:0] BMP_SIG      = 16'h4D42;
	localparam logic [15:0] DEPTH_24     = 16'd24;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		ST_PIXEL,
		ST_BAD_SIG,
		ST_BAD_IMAGE
	} status_t;

	// Header decode results handed to the parser
	typedef struct packed {
		logic             sig_bad;
		logic             image_bad;
		logic             offset_small;
		logic             skip_done;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} hdr_flags_t;

	// Width or height accepted only in 1 .. MAX_DIM (negative values read as huge)
	function automatic logic dim_ok(input logic [31:0] v);
		return (v != 32'd0) && (v <= 32'(MAX_DIM));
	endfunction

endpackage

>>> hw/rtl/bmp24_pixel_deframer.sv
// bmp24_pixel_deframer: top level of the 24-bit BMP byte-stream deframer.
// Uses bmpd_pkg and instantiates bmpd_hdr.

// The block takes one file byte per cycle while the result register is not
// stalled: a byte goes into an input register, is parsed from there by the
// header decoder and pixel assembler, and any result lands in the result
// register. While a stalled result is held there, the input register keeps
// its byte and byte_stall is raised instead of taking a new one. Every
// third pixel byte yields a pixel; header, skipped, padding and trailing
// bytes yield nothing. A bad signature or an unsupported image (depth not
// 24, width or height outside 1..4096) yields one status result and the rest
// of the file is ignored until a byte marked start_of_file. Rows come out
// top-down numbered although the file stores them bottom-up.
module bmp24_pixel_deframer import bmpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         file_byte,
	input  logic               start_of_file,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         status,
	output logic [COORD_W-1:0] column,
	output logic [COORD_W-1:0] row,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [DIM_W-1:0]   image_width,
	output logic [DIM_W-1:0]   image_height,
	output logic               last_pixel
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       advance;

	// Parse state
	phase_t             phase_q, phase_cur, phase_d;
	logic [31:0]        pos_q, pos_cur, pos_d;
	logic [COORD_W-1:0] col_q, col_cur, col_d;
	logic [COORD_W-1:0] frow_q, frow_cur, frow_d;
	logic [1:0]         chan_q, chan_cur, chan_d;
	logic [1:0]         pad_q, pad_cur, pad_d;
	logic [7:0]         blue_q, blue_cur, blue_d;
	logic [7:0]         green_q, green_cur, green_d;
	hdr_flags_t         flags;
	logic               last_col, last_all;

	// Result being formed
	logic               emit;
	status_t            res_status;
	logic [COORD_W-1:0] res_col, res_row;
	logic [7:0]         res_red, res_green, res_blue;
	logic [DIM_W-1:0]   res_w, res_h;
	logic               res_last;

	// Result register
	logic               result_valid_q;
	logic [1:0]         status_q;
	logic [COORD_W-1:0] column_q, row_q;
	logic [7:0]         red_q, green_out_q, blue_out_q;
	logic [DIM_W-1:0]   width_q, height_q;
	logic               last_q;

	// Advance the held byte unless the result register is full and stalled
	assign advance    = valid_s1 && !(result_valid_q && result_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && byte_valid) begin
			byte_s1 <= file_byte;
			sof_s1  <= start_of_file;
		end
	end

	// Start of file restarts the parse from byte zero
	assign phase_cur = sof_s1 ? PH_HEADER : phase_q;
	assign pos_cur   = sof_s1 ? '0 : pos_q;
	assign col_cur   = sof_s1 ? '0 : col_q;
	assign frow_cur  = sof_s1 ? '0 : frow_q;
	assign chan_cur  = sof_s1 ? '0 : chan_q;
	assign pad_cur   = sof_s1 ? '0 : pad_q;
	assign blue_cur  = sof_s1 ? '0 : blue_q;
	assign green_cur = sof_s1 ? '0 : green_q;

	// Saturating byte position
	assign pos_d = (&pos_cur) ? pos_cur : pos_cur + 32'd1;

	bmpd_hdr u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance && (phase_cur == PH_HEADER)),
		.sof    (sof_s1),
		.pos    (pos_cur),
		.data   (byte_s1),
		.flags  (flags)
	);

	assign last_col = ({1'b0, col_cur} + DIM_W'(1)) == flags.width;
	assign last_all = last_col && (({1'b0, frow_cur} + DIM_W'(1)) == flags.height);

	// Next state and result
	always_comb begin
		phase_d    = phase_cur;
		col_d      = col_cur;
		frow_d     = frow_cur;
		chan_d     = chan_cur;
		pad_d      = pad_cur;
		blue_d     = blue_cur;
		green_d    = green_cur;
		emit       = 1'b0;
		res_status = ST_PIXEL;
		res_col    = '0;
		res_row    = '0;
		res_red    = '0;
		res_green  = '0;
		res_blue   = '0;
		res_w      = '0;
		res_h      = '0;
		res_last   = 1'b0;
		unique case (phase_cur)
			PH_HEADER: begin
				if (flags.sig_bad) begin
					emit       = 1'b1;
					res_status = ST_BAD_SIG;
					phase_d    = PH_ERROR;
				end else if (pos_cur == HDR_LAST_POS) begin
					if (flags.image_bad) begin
						emit       = 1'b1;
						res_status = ST_BAD_IMAGE;
						res_w      = flags.width;
						res_h      = flags.height;
						phase_d    = PH_ERROR;
					end else if (flags.offset_small) begin
						phase_d = PH_PIXELS;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (flags.skip_done) begin
					phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (pad_cur != 2'd0) begin
					// drop row padding
					pad_d = pad_cur - 2'd1;
				end else if (chan_cur == 2'd0) begin
					blue_d = byte_s1;
					chan_d = 2'd1;
				end else if (chan_cur == 2'd1) begin
					green_d = byte_s1;
					chan_d  = 2'd2;
				end else begin
					emit      = 1'b1;
					res_col   = col_cur;
					res_row   = COORD_W'(flags.height - DIM_W'(1) - {1'b0, frow_cur});
					res_red   = byte_s1;
					res_green = green_cur;
					res_blue  = blue_cur;
					res_w     = flags.width;
					res_h     = flags.height;
					res_last  = last_all;
					chan_d    = 2'd0;
					if (last_all) begin
						phase_d = PH_DONE;
					end else if (last_col) begin
						col_d  = '0;
						frow_d = frow_cur + COORD_W'(1);
						// rows round up to four bytes: pad = width mod 4
						pad_d  = flags.width[1:0];
					end else begin
						col_d = col_cur + COORD_W'(1);
					end
				end
			end
			PH_DONE, PH_ERROR: begin
			end
			default: begin
			end
		endcase
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			col_q   <= '0;
			frow_q  <= '0;
			chan_q  <= '0;
			pad_q   <= '0;
			blue_q  <= '0;
			green_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			col_q   <= col_d;
			frow_q  <= frow_d;
			chan_q  <= chan_d;
			pad_q   <= pad_d;
			blue_q  <= blue_d;
			green_q <= green_d;
		end
	end

	// Result register: load on a new result, clear when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (!result_valid_q || !result_stall) begin
			result_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status_q    <= res_status;
			column_q    <= res_col;
			row_q       <= res_row;
			red_q       <= res_red;
			green_out_q <= res_green;
			blue_out_q  <= res_blue;
			width_q     <= res_w;
			height_q    <= res_h;
			last_q      <= res_last;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign column       = column_q;
	assign row          = row_q;
	assign red          = red_q;
	assign green        = green_out_q;
	assign blue         = blue_out_q;
	assign image_width  = width_q;
	assign image_height = height_q;
	assign last_pixel   = last_q;

endmodule

>>> hw/rtl/bmpd_hdr.sv
// bmpd_hdr: captures the little-endian header words of a BMP file and
// decodes signature, size, depth and pixel offset checks. Uses bmpd_pkg.
module bmpd_hdr import bmpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic        sof,
	input  logic [31:0] pos,
	input  logic [7:0]  data,
	output hdr_flags_t  flags
);

	logic [15:0] sig_q, sig_cur, sig_d;
	logic [31:0] ofs_q, ofs_cur, ofs_d;
	logic [31:0] wid_q, wid_cur, wid_d;
	logic [31:0] hgt_q, hgt_cur, hgt_d;
	logic [15:0] dep_q, dep_cur, dep_d;
	logic [1:0]  lane;

	// Drop previous file's header on a new file
	assign sig_cur = sof ? '0 : sig_q;
	assign ofs_cur = sof ? '0 : ofs_q;
	assign wid_cur = sof ? '0 : wid_q;
	assign hgt_cur = sof ? '0 : hgt_q;
	assign dep_cur = sof ? '0 : dep_q;

	// Byte lane within a 32-bit field; offset, width and height start at 2 mod 4
	assign lane = 2'(pos[1:0] + 2'd2);

	// Place the byte into the field it belongs to
	always_comb begin
		sig_d = sig_cur;
		ofs_d = ofs_cur;
		wid_d = wid_cur;
		hgt_d = hgt_cur;
		dep_d = dep_cur;
		if (pos < 32'd2) begin
			sig_d[{pos[0], 3'b000} +: 8] = data;
		end else if (pos >= 32'd10 && pos < 32'd14) begin
			ofs_d[{lane, 3'b000} +: 8] = data;
		end else if (pos >= 32'd18 && pos < 32'd22) begin
			wid_d[{lane, 3'b000} +: 8] = data;
		end else if (pos >= 32'd22 && pos < 32'd26) begin
			hgt_d[{lane, 3'b000} +: 8] = data;
		end else if (pos >= 32'd28 && pos < 32'd30) begin
			dep_d[{pos[0], 3'b000} +: 8] = data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q <= '0;
			ofs_q <= '0;
			wid_q <= '0;
			hgt_q <= '0;
			dep_q <= '0;
		end else if (upd) begin
			sig_q <= sig_d;
			ofs_q <= ofs_d;
			wid_q <= wid_d;
			hgt_q <= hgt_d;
			dep_q <= dep_d;
		end
	end

	// Decode checks for the parser
	always_comb begin
		flags.sig_bad      = (pos == 32'd1) && ({data, sig_cur[7:0]} != BMP_SIG);
		flags.image_bad    = (dep_cur != DEPTH_24) || !dim_ok(wid_cur) || !dim_ok(hgt_cur);
		flags.offset_small = ofs_cur <= HDR_BYTES;
		flags.skip_done    = ({1'b0, pos} + 33'd1) >= {1'b0, ofs_cur};
		flags.width        = wid_cur[DIM_W-1:0];
		flags.height       = hgt_cur[DIM_W-1:0];
	end

endmodule

>>> hw/rtl/bmpd_checker.sv
// bmpd_checker: port-level checks for bmp24_pixel_deframer, attached by bind.
// Uses bmpd_pkg.
module bmpd_checker import bmpd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_valid,
	input logic               byte_stall,
	input logic [7:0]         file_byte,
	input logic               start_of_file,
	input logic               result_valid,
	input logic               result_stall,
	input logic [1:0]         status,
	input logic [COORD_W-1:0] column,
	input logic [COORD_W-1:0] row,
	input logic [7:0]         red,
	input logic [7:0]         green,
	input logic [7:0]         blue,
	input logic [DIM_W-1:0]   image_width,
	input logic [DIM_W-1:0]   image_height,
	input logic               last_pixel
);

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) &&
		$stable(column) && $stable(row) && $stable(red) && $stable(last_pixel))
		else $error("stalled result changed");

	// Status results carry no pixel position
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_PIXEL) |->
		column == '0 && row == '0 && !last_pixel)
		else $error("status result with pixel fields");

	// Pixels stay inside the image
	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_PIXEL) |->
		({1'b0, column} < image_width) && ({1'b0, row} < image_height))
		else $error("pixel outside image");

	// Final pixel is the top-right corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_pixel |->
		({1'b0, column} == image_width - DIM_W'(1)) && row == '0)
		else $error("last pixel not at final column of top row");

endmodule

bind bmp24_pixel_deframer bmpd_checker u_bmpd_checker (.*);
